>>> design/dispatch_admission_count_macros.svh
// Assertion macros shared by the dispatch admission count design.
`ifndef DISPATCH_ADMISSION_COUNT_MACROS_SVH
`define DISPATCH_ADMISSION_COUNT_MACROS_SVH

`ifndef SYNTHESIS
`define DAC_ASSERT_SAME(label, clock, reset, cond, expr) \
  label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
    else $error("dispatch admission count check failed");
`define DAC_ASSERT_NEXT(label, clock, reset, cond, expr) \
  label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
    else $error("dispatch admission count check failed");
`else
`define DAC_ASSERT_SAME(label, clock, reset, cond, expr)
`define DAC_ASSERT_NEXT(label, clock, reset, cond, expr)
`endif

`endif

>>> design/dac_pkg.sv
`default_nettype none

package dac_pkg;

  localparam int QueueDepth = 16;
  localparam int NumQueues  = 3;
  localparam int NumSlots   = 2;

  typedef enum logic [2:0] {
    REG_Q0_MASK  = 3'd0,
    REG_Q1_MASK  = 3'd1,
    REG_Q2_MASK  = 3'd2,
    REG_Q0_WIDTH = 3'd3,
    REG_Q1_WIDTH = 3'd4,
    REG_Q2_WIDTH = 3'd5,
    REG_ALU_TYPE = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [NumQueues-1:0][7:0] mask;
    logic [NumQueues-1:0][1:0] width;
    logic [2:0]                alu_type;
  } cfg_t;

  typedef struct packed {
    logic       exception;
    logic [2:0] func_type;
    logic [4:0] dest_reg;
    logic       control_flow;
  } inst_t;

  typedef struct packed {
    logic [1:0]                remaining;
    logic                      stop;
    logic [1:0]                count;
    logic [NumQueues-1:0][1:0] ports;
    inst_t [NumSlots-1:0]      inst;
  } token_t;

  function automatic logic [1:0] port_count(input logic [4:0] free, input logic [1:0] width);
    logic [8:0] f;
    f = {4'b0, free};
    if (f > 9'(QueueDepth)) begin
      f = 9'(QueueDepth);
    end
    if ({7'b0, width} <= f) begin
      return width;
    end
    return f[1:0];
  endfunction

endpackage

`default_nettype wire

>>> design/dac_pkt_if.sv
`default_nettype none

interface dac_pkt_if;
  logic       valid;
  logic       ready;
  logic [1:0] packet_size;
  logic       first_exception;
  logic [2:0] first_func_type;
  logic [4:0] first_dest_reg;
  logic       first_control_flow;
  logic       second_exception;
  logic [2:0] second_func_type;
  logic [4:0] second_dest_reg;
  logic       second_control_flow;
  logic [4:0] queue0_free;
  logic [4:0] queue1_free;
  logic [4:0] queue2_free;

  modport source (
    output valid, packet_size, first_exception, first_func_type, first_dest_reg,
           first_control_flow, second_exception, second_func_type, second_dest_reg,
           second_control_flow, queue0_free, queue1_free, queue2_free,
    input  ready
  );

  modport sink (
    input  valid, packet_size, first_exception, first_func_type, first_dest_reg,
           first_control_flow, second_exception, second_func_type, second_dest_reg,
           second_control_flow, queue0_free, queue1_free, queue2_free,
    output ready
  );
endinterface

`default_nettype wire

>>> design/dac_result_if.sv
`default_nettype none

interface dac_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] dispatch_count;

  modport source (output valid, dispatch_count, input ready);
  modport sink (input valid, dispatch_count, output ready);
endinterface

`default_nettype wire

>>> design/dac_slot_cell.sv
`default_nettype none
`include "dispatch_admission_count_macros.svh"

module dac_slot_cell (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire dac_pkg::cfg_t   cfg,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire dac_pkg::token_t tok_in,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output dac_pkg::token_t      tok_out
);
  import dac_pkg::*;

  logic   vld;
  token_t tok;
  token_t tok_next;
  logic   go;
  logic   found;
  inst_t  cur;

  assign in_ready  = !vld || out_ready;
  assign out_valid = vld;
  assign tok_out   = tok;

  always_comb begin
    tok_next         = tok_in;
    cur              = tok_in.inst[0];
    found            = 1'b0;
    go               = (tok_in.remaining != 2'd0) && !tok_in.stop;
    tok_next.inst[0] = tok_in.inst[1];
    if (go) begin
      tok_next.remaining = tok_in.remaining - 2'd1;
      if (cur.exception) begin
        tok_next.count = tok_in.count + 2'd1;
        tok_next.stop  = 1'b1;
      end else if (cur.func_type == cfg.alu_type && cur.dest_reg == 5'd0) begin
        tok_next.count = tok_in.count + 2'd1;
      end else begin
        for (int q = 0; q < NumQueues; q++) begin
          if (!found && cfg.mask[q][cur.func_type] && tok_in.ports[q] != 2'd0) begin
            found             = 1'b1;
            tok_next.ports[q] = tok_in.ports[q] - 2'd1;
          end
        end
        if (found) begin
          tok_next.count = tok_in.count + 2'd1;
        end
        if (!found || cur.control_flow) begin
          tok_next.stop = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      tok <= tok_next;
    end
  end

  `DAC_ASSERT_NEXT(a_stopped_holds_count, clk, rst, in_valid && in_ready && tok_in.stop,
                   tok.count == $past(tok_in.count))
  `DAC_ASSERT_NEXT(a_count_step, clk, rst, in_valid && in_ready,
                   tok.count == $past(tok_in.count) || tok.count == $past(tok_in.count) + 2'd1)
  `DAC_ASSERT_NEXT(a_port_use, clk, rst, in_valid && in_ready,
                   tok.ports[0] <= $past(tok_in.ports[0]))
  `DAC_ASSERT_SAME(a_count_range, clk, rst, vld, tok.count <= 2'd2)

endmodule

`default_nettype wire

>>> design/dispatch_admission_count.sv
// Dispatch admission count.
// A packet of up to two decoded instructions arrives on the pkt channel with
// the free entry counts of three issue queues; the number of leading
// instructions that can be dispatched leaves on the result channel, one result
// for each packet. Both channels complete a transaction when valid and ready
// are high at a rising clock edge. The queue type masks, enqueue widths and
// the ALU type code are written through cfg_we, cfg_index and cfg_data.
// Each instruction slot is decided by one cell of a two-cell chain, each cell
// ending in a register, so a result passes through the registers of both cells
// before it leaves; a new packet can be taken every cycle while not stalled.
// When the receiver stalls, the chain holds its contents and a cell keeps
// taking data only while its own register is free or drained in that cycle.
// A synchronous reset empties the chain and loads the register defaults.
`default_nettype none

module dispatch_admission_count (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_data,
  dac_pkt_if.sink    pkt,
  dac_result_if.source result
);
  import dac_pkg::*;

  cfg_t   cfg;
  token_t tok_in;
  token_t tok_mid;
  token_t tok_last;
  logic   mid_valid;
  logic   mid_ready;
  logic   last_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mask     <= {8'd0, 8'd0, 8'd255};
      cfg.width    <= {2'd2, 2'd2, 2'd2};
      cfg.alu_type <= 3'd0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_Q0_MASK:  cfg.mask[0]  <= cfg_data;
        REG_Q1_MASK:  cfg.mask[1]  <= cfg_data;
        REG_Q2_MASK:  cfg.mask[2]  <= cfg_data;
        REG_Q0_WIDTH: cfg.width[0] <= cfg_data[1:0];
        REG_Q1_WIDTH: cfg.width[1] <= cfg_data[1:0];
        REG_Q2_WIDTH: cfg.width[2] <= cfg_data[1:0];
        REG_ALU_TYPE: cfg.alu_type <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    tok_in.remaining = (pkt.packet_size == 2'd3) ? 2'd2 : pkt.packet_size;
    tok_in.stop      = 1'b0;
    tok_in.count     = 2'd0;
    tok_in.ports[0]  = port_count(pkt.queue0_free, cfg.width[0]);
    tok_in.ports[1]  = port_count(pkt.queue1_free, cfg.width[1]);
    tok_in.ports[2]  = port_count(pkt.queue2_free, cfg.width[2]);
    tok_in.inst[0]   = '{exception: pkt.first_exception, func_type: pkt.first_func_type,
                         dest_reg: pkt.first_dest_reg, control_flow: pkt.first_control_flow};
    tok_in.inst[1]   = '{exception: pkt.second_exception, func_type: pkt.second_func_type,
                         dest_reg: pkt.second_dest_reg,
                         control_flow: pkt.second_control_flow};
  end

  dac_slot_cell u_cell0 (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (pkt.valid),
    .in_ready  (pkt.ready),
    .tok_in    (tok_in),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .tok_out   (tok_mid)
  );

  dac_slot_cell u_cell1 (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (mid_valid),
    .in_ready  (mid_ready),
    .tok_in    (tok_mid),
    .out_valid (last_valid),
    .out_ready (result.ready),
    .tok_out   (tok_last)
  );

  assign result.valid          = last_valid;
  assign result.dispatch_count = tok_last.count;

endmodule

`default_nettype wire
